// ===== design/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants of the JSON string unescaper
// Escape modes, command and status structures between the controller and
// the datapath, and the helper functions for escape letters and hex digits.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int UNIT_W = 16;

    localparam logic [UNIT_W-1:0] CH_BACKSLASH = 16'h005C;
    localparam logic [UNIT_W-1:0] CH_U         = 16'h0075;
    localparam logic [UNIT_W-1:0] CH_B         = 16'h0062;
    localparam logic [UNIT_W-1:0] CH_F         = 16'h0066;
    localparam logic [UNIT_W-1:0] CH_N         = 16'h006E;
    localparam logic [UNIT_W-1:0] CH_R         = 16'h0072;
    localparam logic [UNIT_W-1:0] CH_T         = 16'h0074;

    // Escape decoder modes; the fourth code behaves as normal.
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_ESCAPE = 2'd1;
    localparam logic [1:0] MODE_HEX    = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       accept;
        logic       emit;
        logic       sel_tail;
        logic       eom;
        logic [1:0] rep_idx;
    } jsu_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       slot_free;
        logic [1:0] rep_n;
        logic       tail_valid;
        logic       last;
    } jsu_sts_t;

    // Named escape letters map to control characters, others to themselves.
    function automatic logic [UNIT_W-1:0] map_escape(input logic [UNIT_W-1:0] c);
        logic [UNIT_W-1:0] r;
        r = c;
        if (c == CH_B) r = 16'd8;
        if (c == CH_F) r = 16'd12;
        if (c == CH_N) r = 16'd10;
        if (c == CH_R) r = 16'd13;
        if (c == CH_T) r = 16'd9;
        return r;
    endfunction

    // Hex digit of either case: bit 4 flags a valid digit, bits 3:0 its value.
    function automatic logic [4:0] hex_digit(input logic [UNIT_W-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 16'h0030 && c <= 16'h0039) r = {1'b1, c[3:0]};
        if (c >= 16'h0061 && c <= 16'h0066) r = {1'b1, c[3:0] + 4'd9};
        if (c >= 16'h0041 && c <= 16'h0046) r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

endpackage

// ===== design/jsu_datapath.sv =====
// ----------------------------------------------------------------------------
// jsu_datapath: escape decoder state, hex buffer and output register
// Decodes each accepted code unit into a replay count and an optional tail
// result, keeps the escape state and drives the result channel registers.
// ----------------------------------------------------------------------------
module jsu_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [jsu_pkg::UNIT_W-1:0] s_code_unit,
    input  logic                       s_first,
    input  logic                       s_last,
    input  logic                       s_wrapped,
    input  jsu_pkg::jsu_cmd_t          cmd,
    output jsu_pkg::jsu_sts_t          sts,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [jsu_pkg::UNIT_W-1:0] m_out_unit,
    output logic                       m_has_char,
    output logic                       m_end_of_message
);
    import jsu_pkg::*;

    logic [1:0]        mode_reg, mode_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic [UNIT_W-1:0] val_reg, val_next;
    logic [UNIT_W-1:0] hbuf_reg [4];
    logic [UNIT_W-1:0] tail_unit_reg, tail_unit_next;
    logic              tail_has_reg, tail_has_next;
    logic              buf_wr;
    logic              m_valid_reg;
    logic [UNIT_W-1:0] m_unit_reg;
    logic              m_has_reg;
    logic              m_eom_reg;
    logic [1:0]        rep_n;
    logic              tail_valid;

    // Decode of the offered item against the current escape state.
    always_comb begin
        logic [1:0] mode_eff;
        logic [1:0] cnt_eff;
        logic [2:0] cnt_inc;
        logic [4:0] dig;
        mode_eff       = s_first ? MODE_NORMAL : mode_reg;
        cnt_eff        = s_first ? 2'd0 : cnt_reg;
        cnt_inc        = {1'b0, cnt_eff} + 3'd1;
        dig            = hex_digit(s_code_unit);
        mode_next      = mode_eff;
        cnt_next       = cnt_eff;
        val_next       = val_reg;
        buf_wr         = 1'b0;
        rep_n          = 2'd0;
        tail_valid     = 1'b0;
        tail_has_next  = 1'b1;
        tail_unit_next = s_code_unit;
        if (s_wrapped && (s_first || s_last)) begin
            // Framing quote: flush any pending escape at the closing one.
            if (s_last) begin
                if (mode_eff == MODE_ESCAPE) begin
                    tail_valid     = 1'b1;
                    tail_unit_next = CH_BACKSLASH;
                end else if (mode_eff == MODE_HEX) begin
                    rep_n = cnt_eff;
                end
            end
        end else begin
            case (mode_eff)
                MODE_ESCAPE: begin
                    mode_next = MODE_NORMAL;
                    if (s_code_unit == CH_U) begin
                        if (!s_last) begin
                            mode_next = MODE_HEX;
                            cnt_next  = 2'd0;
                            val_next  = '0;
                        end
                    end else begin
                        tail_valid     = 1'b1;
                        tail_unit_next = map_escape(s_code_unit);
                    end
                end
                MODE_HEX: begin
                    mode_next = MODE_NORMAL;
                    cnt_next  = 2'd0;
                    if (dig[4]) begin
                        val_next = {val_reg[UNIT_W-5:0], dig[3:0]};
                        buf_wr   = 1'b1;
                        if (cnt_inc[2]) begin
                            tail_valid     = 1'b1;
                            tail_unit_next = {val_reg[UNIT_W-5:0], dig[3:0]};
                        end else if (s_last) begin
                            rep_n = cnt_inc[1:0];
                        end else begin
                            mode_next = MODE_HEX;
                            cnt_next  = cnt_inc[1:0];
                        end
                    end else begin
                        // Broken sequence: replay digits, then treat as plain.
                        rep_n = cnt_eff;
                        if (s_code_unit == CH_BACKSLASH && !s_last) begin
                            mode_next = MODE_ESCAPE;
                        end else begin
                            tail_valid = 1'b1;
                        end
                    end
                end
                default: begin
                    mode_next = MODE_NORMAL;
                    if (s_code_unit == CH_BACKSLASH && !s_last) begin
                        mode_next = MODE_ESCAPE;
                    end else begin
                        tail_valid = 1'b1;
                    end
                end
            endcase
        end
        // A message end with nothing to show gives a bare end marker.
        if (s_last) begin
            mode_next = MODE_NORMAL;
            cnt_next  = 2'd0;
            if (rep_n == 2'd0 && !tail_valid) begin
                tail_valid     = 1'b1;
                tail_has_next  = 1'b0;
                tail_unit_next = '0;
            end
        end
    end

    // Escape state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NORMAL;
            cnt_reg  <= 2'd0;
            val_reg  <= '0;
        end else if (cmd.accept) begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            val_reg  <= val_next;
        end
    end

    // Hex digit buffer and tail result; no reset needed.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            tail_unit_reg <= tail_unit_next;
            tail_has_reg  <= tail_has_next;
            if (buf_wr) begin
                hbuf_reg[s_first ? 2'd0 : cnt_reg] <= s_code_unit;
            end
        end
    end

    // Output register of the result channel.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_unit_reg <= cmd.sel_tail ? tail_unit_reg : hbuf_reg[cmd.rep_idx];
            m_has_reg  <= cmd.sel_tail ? tail_has_reg : 1'b1;
            m_eom_reg  <= cmd.eom;
        end
    end

    assign sts.slot_free  = !m_valid_reg || m_ready;
    assign sts.rep_n      = rep_n;
    assign sts.tail_valid = tail_valid;
    assign sts.last       = s_last;

    assign m_valid          = m_valid_reg;
    assign m_out_unit       = m_unit_reg;
    assign m_has_char       = m_has_reg;
    assign m_end_of_message = m_eom_reg;

endmodule

// ===== design/jsu_ctrl.sv =====
// ----------------------------------------------------------------------------
// jsu_ctrl: result sequencer of the JSON string unescaper
// Accepts items and steps through the replayed digits and the tail result
// of each one, one result transaction per free output slot.
// ----------------------------------------------------------------------------
module jsu_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  jsu_pkg::jsu_sts_t sts,
    output jsu_pkg::jsu_cmd_t cmd
);
    import jsu_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] rep_left_reg, rep_left_next;
    logic [1:0] rep_idx_reg, rep_idx_next;
    logic       tail_reg, tail_next;
    logic       last_reg, last_next;
    logic       pend_any;
    logic       pend_one;
    logic       done_now;
    logic       emit;
    logic       accept;

    // Pending work of the current item.
    assign pend_any = (rep_left_reg != 2'd0) || tail_reg;
    assign pend_one = (rep_left_reg == 2'd1 && !tail_reg) ||
                      (rep_left_reg == 2'd0 && tail_reg);
    assign emit     = (state_reg == ST_EMIT) && pend_any && sts.slot_free;
    assign done_now = (state_reg == ST_IDLE) || !pend_any ||
                      (pend_one && sts.slot_free);
    assign s_ready  = done_now;
    assign accept   = s_valid && done_now;

    // Sequencer next state.
    always_comb begin
        state_next    = state_reg;
        rep_left_next = rep_left_reg;
        rep_idx_next  = rep_idx_reg;
        tail_next     = tail_reg;
        last_next     = last_reg;
        if (emit) begin
            if (rep_left_reg != 2'd0) begin
                rep_left_next = rep_left_reg - 2'd1;
                rep_idx_next  = rep_idx_reg + 2'd1;
            end else begin
                tail_next = 1'b0;
            end
        end
        if (accept) begin
            state_next    = ST_EMIT;
            rep_left_next = sts.rep_n;
            rep_idx_next  = 2'd0;
            tail_next     = sts.tail_valid;
            last_next     = sts.last;
        end else if (state_reg == ST_EMIT && done_now) begin
            state_next = ST_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rep_left_reg <= 2'd0;
            rep_idx_reg  <= 2'd0;
            tail_reg     <= 1'b0;
            last_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rep_left_reg <= rep_left_next;
            rep_idx_reg  <= rep_idx_next;
            tail_reg     <= tail_next;
            last_reg     <= last_next;
        end
    end

    assign cmd.accept   = accept;
    assign cmd.emit     = emit;
    assign cmd.sel_tail = (rep_left_reg == 2'd0);
    assign cmd.eom      = last_reg && pend_one;
    assign cmd.rep_idx  = rep_idx_reg;

    // An accepted item always leaves the sequencer busy with it.
    a_accept_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_EMIT)
        else $error("sequencer not busy after an accepted item");

    // Pending work only exists while emitting.
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !pend_any)
        else $error("pending results while idle");

    // A result is only loaded into a free output slot.
    a_emit_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> sts.slot_free)
        else $error("result loaded into an occupied output slot");

    // The end marker is set only on the final result of an item.
    a_eom_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && cmd.eom) |=> !pend_any || state_reg == ST_EMIT)
        else $error("end marker before the final result");

endmodule

// ===== design/json_string_unescape_core.sv =====
// Path: an item is registered in the sequencer, then each result in the output register.
// Throughput: one item per cycle while each yields at most one result and the output
// slot is free; an item that replays buffered hex digits holds input until its last
// result is loaded; the sequencer fills the single output register at one result per free cycle.
// Reset: synchronous, active low; clears the escape state, sequencer and output valid.
// ----------------------------------------------------------------------------
// json_string_unescape_core: streaming unescaper for JSON string text
// Takes one UTF-16 code unit per transaction, resolves escapes and \u
// sequences and delivers the decoded units with an end of message mark.
// ----------------------------------------------------------------------------
module json_string_unescape_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [jsu_pkg::UNIT_W-1:0] s_code_unit,
    input  logic                       s_first,
    input  logic                       s_last,
    input  logic                       s_wrapped,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [jsu_pkg::UNIT_W-1:0] m_out_unit,
    output logic                       m_has_char,
    output logic                       m_end_of_message
);
    import jsu_pkg::*;

    jsu_cmd_t cmd;
    jsu_sts_t sts;

    // Result sequencer.
    jsu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Decoder state and output register.
    jsu_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_code_unit      (s_code_unit),
        .s_first          (s_first),
        .s_last           (s_last),
        .s_wrapped        (s_wrapped),
        .cmd              (cmd),
        .sts              (sts),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_unit       (m_out_unit),
        .m_has_char       (m_has_char),
        .m_end_of_message (m_end_of_message)
    );

endmodule
